@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the mixer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("invariant violated");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication violated");

`endif

@@ rtl/core/afmix_pkg.sv @@
// Shared types and constants for the two-source audio FIFO mixer.
package afmix_pkg;

  localparam int SMP_W  = 16;
  localparam int BLEN_W = 15;
  localparam int CUSH_W = 14;
  localparam int FADE_W = 15;
  localparam int CFG_W  = 15;
  localparam int SUM_W  = 17;   // holds block_len + cushion and any depth up to 65536
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  localparam logic [CUSH_W-1:0] CUSHION_RST = 14'd1024;
  localparam logic [FADE_W-1:0] FADE_RST    = 15'd800;

  localparam logic signed [SMP_W-1:0] SMP_MAX = 16'sh7FFF;
  localparam logic signed [SMP_W-1:0] SMP_MIN = 16'sh8000;

  typedef enum logic [1:0] {
    OP_PUSH_A = 2'd0,
    OP_PUSH_B = 2'd1,
    OP_PULL   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic {
    CFG_CUSHION = 1'b0,
    CFG_FADE    = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    op_t                     op;
    logic                    zero_len;
    logic signed [SMP_W-1:0] sample;
    logic [BLEN_W-1:0]       block_len;
  } req_t;

  typedef struct packed {
    logic valid;
    req_t req;
  } q_head_t;

endpackage

@@ rtl/core/afmix_front.sv @@
// Front end: accepts requests, decodes them and buffers them in a short queue.
`include "assert_macros.svh"

module afmix_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [1:0]                            in_op,
  input  logic signed [afmix_pkg::SMP_W-1:0]    in_sample,
  input  logic [afmix_pkg::BLEN_W-1:0]          in_block_len,
  output afmix_pkg::q_head_t                    head,
  input  logic                                  pop
);
  import afmix_pkg::*;

  req_t            q_r [Q_DEPTH];
  req_t            req_in;
  logic [Q_AW-1:0] wr_idx_r, rd_idx_r;
  logic [Q_AW:0]   cnt_r, cnt_nxt;
  logic            push, do_pop;

  always_comb begin
    req_in.op        = op_t'(in_op);
    req_in.zero_len  = (in_block_len == '0);
    req_in.sample    = in_sample;
    req_in.block_len = in_block_len;
  end

  assign in_stall = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign push     = in_valid && !in_stall;
  assign do_pop   = pop && (cnt_r != '0);
  assign cnt_nxt  = cnt_r + (Q_AW+1)'(push) - (Q_AW+1)'(do_pop);

  assign head.valid = (cnt_r != '0);
  assign head.req   = q_r[rd_idx_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_idx_r] <= req_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_idx_r <= wr_idx_r + 1'b1;
      end
      if (do_pop) begin
        rd_idx_r <= rd_idx_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  `ASSERT_IMPLY(a_pop_nonempty, clk, rst_n, pop, cnt_r != '0)

endmodule

@@ rtl/core/afmix_back.sv @@
// Back end: sample stores, block bookkeeping, fade and saturating mix.
`include "assert_macros.svh"

module afmix_back #(
  parameter int DEPTH = 16384
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  afmix_pkg::q_head_t                   head,
  output logic                                 pop,
  input  logic [afmix_pkg::CUSH_W-1:0]         cushion,
  input  logic [afmix_pkg::FADE_W-1:0]         fade_dec,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [afmix_pkg::SMP_W-1:0]   out_mixed_sample,
  output logic                                 out_last_of_block
);
  import afmix_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);
  localparam logic [SUM_W-1:0] TGT_MAX = SUM_W'(DEPTH - 2);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_OPEN = 5'b00010,
    ST_TRIM = 5'b00100,
    ST_READ = 5'b01000,
    ST_MIX  = 5'b10000
  } state_t;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [SUM_W-1:0] fill_of(input logic [PW-1:0] rd,
                                                input logic [PW-1:0] wr);
    return (wr >= rd) ? SUM_W'(wr) - SUM_W'(rd) : DEPTH_S + SUM_W'(wr) - SUM_W'(rd);
  endfunction

  function automatic logic [PW-1:0] trim_ptr(input logic [PW-1:0] wr,
                                             input logic [SUM_W-1:0] tgt);
    return (SUM_W'(wr) >= tgt) ? PW'(SUM_W'(wr) - tgt) : PW'(DEPTH_S + SUM_W'(wr) - tgt);
  endfunction

  function automatic logic signed [SMP_W-1:0] fade(input logic signed [SMP_W-1:0] h,
                                                   input logic [FADE_W-1:0] s);
    logic signed [SMP_W:0] hx, sx, r;
    hx = {h[SMP_W-1], h};
    sx = $signed({2'b00, s});
    if (hx > sx) begin
      r = hx - sx;
    end else if (hx < -sx) begin
      r = hx + sx;
    end else begin
      r = '0;
    end
    return r[SMP_W-1:0];
  endfunction

  logic signed [SMP_W-1:0] mem_a [DEPTH];
  logic signed [SMP_W-1:0] mem_b [DEPTH];
  logic signed [SMP_W-1:0] rdata_a_r, rdata_b_r;

  state_t                  state_r, state_nxt;
  logic [PW-1:0]           rd_a_r, wr_a_r, rd_b_r, wr_b_r;
  logic [PW-1:0]           takes_a_r, takes_b_r;
  logic signed [SMP_W-1:0] held_a_r, held_b_r;
  logic [BLEN_W-1:0]       blk_rem_r, blen_r;
  logic                    silent_r;
  logic [SUM_W-1:0]        fill_a_r, fill_b_r, target_r;
  logic                    out_valid_r, out_last_r;
  logic signed [SMP_W-1:0] out_smp_r;

  logic [SUM_W-1:0]        fill_a, fill_b, tgt_raw, eff_a, eff_b;
  logic                    full_a, full_b, wen_a, wen_b, mix_go;
  logic [PW-1:0]           take_a, take_b;
  logic signed [SMP_W-1:0] nxt_a, nxt_b, mix_smp;
  logic signed [SMP_W:0]   sum;
  logic [BLEN_W-1:0]       rem_dec;

  assign fill_a  = fill_of(rd_a_r, wr_a_r);
  assign fill_b  = fill_of(rd_b_r, wr_b_r);
  assign full_a  = (ptr_inc(wr_a_r) == rd_a_r);
  assign full_b  = (ptr_inc(wr_b_r) == rd_b_r);
  assign tgt_raw = SUM_W'(blen_r) + SUM_W'(cushion);

  assign pop   = (state_r == ST_IDLE) && head.valid;
  assign wen_a = pop && (head.req.op == OP_PUSH_A) && !full_a;
  assign wen_b = pop && (head.req.op == OP_PUSH_B) && !full_b;

  // trim result: fill after dropping the oldest samples, then the take count
  assign eff_a  = (fill_a_r > target_r) ? target_r : fill_a_r;
  assign eff_b  = (fill_b_r > target_r) ? target_r : fill_b_r;
  assign take_a = (SUM_W'(blen_r) < eff_a) ? PW'(blen_r) : PW'(eff_a);
  assign take_b = (SUM_W'(blen_r) < eff_b) ? PW'(blen_r) : PW'(eff_b);

  assign nxt_a   = (takes_a_r != '0) ? rdata_a_r : fade(held_a_r, fade_dec);
  assign nxt_b   = (takes_b_r != '0) ? rdata_b_r : fade(held_b_r, fade_dec);
  assign sum     = {nxt_a[SMP_W-1], nxt_a} + {nxt_b[SMP_W-1], nxt_b};
  assign rem_dec = blk_rem_r - 1'b1;
  assign mix_go  = (state_r == ST_MIX) && (!out_valid_r || !out_stall);

  always_comb begin
    priority if (silent_r) begin
      mix_smp = '0;
    end else if (sum > $signed({SMP_MAX[SMP_W-1], SMP_MAX})) begin
      mix_smp = SMP_MAX;
    end else if (sum < $signed({SMP_MIN[SMP_W-1], SMP_MIN})) begin
      mix_smp = SMP_MIN;
    end else begin
      mix_smp = sum[SMP_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (head.valid && head.req.op == OP_PULL) begin
          if (blk_rem_r != '0) begin
            state_nxt = ST_READ;
          end else if (!head.req.zero_len) begin
            state_nxt = ST_OPEN;
          end
        end
      end
      ST_OPEN: state_nxt = ST_TRIM;
      ST_TRIM: state_nxt = ST_READ;
      ST_READ: state_nxt = ST_MIX;
      ST_MIX: begin
        if (mix_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sample stores with registered read at the current read pointers
  always_ff @(posedge clk) begin
    if (wen_a) begin
      mem_a[wr_a_r] <= head.req.sample;
    end
    rdata_a_r <= mem_a[rd_a_r];
  end

  always_ff @(posedge clk) begin
    if (wen_b) begin
      mem_b[wr_b_r] <= head.req.sample;
    end
    rdata_b_r <= mem_b[rd_b_r];
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      blen_r <= head.req.block_len;
    end
    if (state_r == ST_OPEN) begin
      fill_a_r <= fill_a;
      fill_b_r <= fill_b;
      target_r <= (tgt_raw > TGT_MAX) ? TGT_MAX : tgt_raw;
    end
    if (mix_go) begin
      out_smp_r  <= mix_smp;
      out_last_r <= (rem_dec == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_a_r      <= '0;
      wr_a_r      <= '0;
      rd_b_r      <= '0;
      wr_b_r      <= '0;
      takes_a_r   <= '0;
      takes_b_r   <= '0;
      held_a_r    <= '0;
      held_b_r    <= '0;
      blk_rem_r   <= '0;
      silent_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= mix_go || (out_valid_r && out_stall);
      if (wen_a) begin
        wr_a_r <= ptr_inc(wr_a_r);
      end
      if (wen_b) begin
        wr_b_r <= ptr_inc(wr_b_r);
      end
      if (pop && head.req.op == OP_CLEAR) begin
        rd_a_r    <= '0;
        wr_a_r    <= '0;
        rd_b_r    <= '0;
        wr_b_r    <= '0;
        takes_a_r <= '0;
        takes_b_r <= '0;
        held_a_r  <= '0;
        held_b_r  <= '0;
        blk_rem_r <= '0;
        silent_r  <= 1'b0;
      end
      if (state_r == ST_TRIM) begin
        if (fill_a_r > target_r) begin
          rd_a_r <= trim_ptr(wr_a_r, target_r);
        end
        if (fill_b_r > target_r) begin
          rd_b_r <= trim_ptr(wr_b_r, target_r);
        end
        blk_rem_r <= blen_r;
        if (fill_a_r == '0 && fill_b_r == '0) begin
          silent_r  <= 1'b1;
          held_a_r  <= '0;
          held_b_r  <= '0;
          takes_a_r <= '0;
          takes_b_r <= '0;
        end else begin
          silent_r  <= 1'b0;
          takes_a_r <= take_a;
          takes_b_r <= take_b;
        end
      end
      if (mix_go) begin
        blk_rem_r <= rem_dec;
        if (rem_dec == '0) begin
          silent_r <= 1'b0;
        end
        if (!silent_r) begin
          held_a_r <= nxt_a;
          held_b_r <= nxt_b;
          if (takes_a_r != '0) begin
            rd_a_r    <= ptr_inc(rd_a_r);
            takes_a_r <= takes_a_r - 1'b1;
          end
          if (takes_b_r != '0) begin
            rd_b_r    <= ptr_inc(rd_b_r);
            takes_b_r <= takes_b_r - 1'b1;
          end
        end
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_mixed_sample  = out_smp_r;
  assign out_last_of_block = out_last_r;

  // takes never reach past written entries
  `ASSERT_ALWAYS(a_takes_a_bound, clk, rst_n,
                 SUM_W'(takes_a_r) <= fill_a)
  `ASSERT_ALWAYS(a_takes_b_bound, clk, rst_n,
                 SUM_W'(takes_b_r) <= fill_b)
  `ASSERT_IMPLY(a_silent_no_takes, clk, rst_n, silent_r,
                takes_a_r == '0 && takes_b_r == '0)
  `ASSERT_IMPLY(a_silent_in_block, clk, rst_n, blk_rem_r == '0, !silent_r)

endmodule

@@ rtl/core/two_source_audio_fifo_mixer_unit.sv @@
// Top level of the two-source audio FIFO mixer: config registers, front and back.
//
//   port group  direction  flow control       contents
//   in_*        input      valid / stall      op, sample, block_len
//   out_*       output     valid / stall      mixed_sample, last_of_block
//   cfg_*       input      write enable only  index, write data
//
// Push and clear requests are taken in the back end's idle state; a pull inside an open
// block steps through store read, then mix, and a pull that opens a block steps through
// fill/target, trim, read, mix. The store read port sets the read step of a pull.
// A four-entry request queue decouples intake from the back end.
// Reset is synchronous; stores are not cleared, no sweep is needed.
// A stalled result holds the back end in its mix step until taken.
`include "assert_macros.svh"

module two_source_audio_fifo_mixer_unit #(
  parameter int DEPTH = 16384
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           in_op,
  input  logic signed [afmix_pkg::SMP_W-1:0]   in_sample,
  input  logic [afmix_pkg::BLEN_W-1:0]         in_block_len,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [afmix_pkg::SMP_W-1:0]   out_mixed_sample,
  output logic                                 out_last_of_block,
  input  logic                                 cfg_we,
  input  logic [0:0]                           cfg_index,
  input  logic [afmix_pkg::CFG_W-1:0]          cfg_wdata
);
  import afmix_pkg::*;

  logic [CUSH_W-1:0] cushion_r;
  logic [FADE_W-1:0] fade_r;
  q_head_t           head;
  logic              pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cushion_r <= CUSHION_RST;
      fade_r    <= FADE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CUSHION: cushion_r <= cfg_wdata[CUSH_W-1:0];
        CFG_FADE:    fade_r    <= cfg_wdata[FADE_W-1:0];
        default:     ;
      endcase
    end
  end

  afmix_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_sample    (in_sample),
    .in_block_len (in_block_len),
    .head         (head),
    .pop          (pop)
  );

  afmix_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head),
    .pop               (pop),
    .cushion           (cushion_r),
    .fade_dec          (fade_r),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_mixed_sample  (out_mixed_sample),
    .out_last_of_block (out_last_of_block)
  );

endmodule
